### src/chrf_pkg.sv
// ----------------------------------------------------------------------------
// Coprocessor host register file package
// Payload types, memory layout and register offsets of the host window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chrf_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  addr;
    logic [7:0]  wdata;
    logic [23:0] core_mdr;
    logic        core_bus_access;
    logic        core_busy;
  } in_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        irq_line;
    logic        start_pulse;
    logic [22:0] start_pc;
    logic        dma_start;
    logic        cache_load_start;
    logic        suspend_active;
    logic [7:0]  suspend_cycles;
    logic        halted;
  } out_t;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_HALT  = 2'd2;
  localparam logic [1:0] REQ_IRQ   = 2'd3;

  localparam int MEM_DEPTH = 80;
  localparam int MEM_AW    = 7;
  localparam logic [MEM_AW-1:0] GPR_BASE = 7'd32;

  localparam logic [9:0] A_DMA_SRC0      = 10'h340;
  localparam logic [9:0] A_DMA_SRC1      = 10'h341;
  localparam logic [9:0] A_DMA_SRC2      = 10'h342;
  localparam logic [9:0] A_DMA_LEN0      = 10'h343;
  localparam logic [9:0] A_DMA_LEN1      = 10'h344;
  localparam logic [9:0] A_DMA_TGT0      = 10'h345;
  localparam logic [9:0] A_DMA_TGT1      = 10'h346;
  localparam logic [9:0] A_DMA_TGT2      = 10'h347;
  localparam logic [9:0] A_CACHE_PRELOAD = 10'h348;
  localparam logic [9:0] A_PROG_OFS0     = 10'h349;
  localparam logic [9:0] A_PROG_OFS1     = 10'h34a;
  localparam logic [9:0] A_PROG_OFS2     = 10'h34b;
  localparam logic [9:0] A_CACHE_LOCK    = 10'h34c;
  localparam logic [9:0] A_PAGE_LO       = 10'h34d;
  localparam logic [9:0] A_PAGE_HI       = 10'h34e;
  localparam logic [9:0] A_PC_BYTE       = 10'h34f;
  localparam logic [9:0] A_WAIT_STATES   = 10'h350;
  localparam logic [9:0] A_IRQ_DISABLE   = 10'h351;
  localparam logic [9:0] A_SPARE_BIT     = 10'h352;
  localparam logic [9:0] A_HALT          = 10'h353;
  localparam logic [9:0] A_STATUS_ALT    = 10'h354;
  localparam logic [9:0] A_SUSPEND_0     = 10'h355;
  localparam logic [9:0] A_SUSPEND_1     = 10'h356;
  localparam logic [9:0] A_SUSPEND_2     = 10'h357;
  localparam logic [9:0] A_SUSPEND_3     = 10'h358;
  localparam logic [9:0] A_SUSPEND_4     = 10'h359;
  localparam logic [9:0] A_SUSPEND_5     = 10'h35a;
  localparam logic [9:0] A_SUSPEND_6     = 10'h35b;
  localparam logic [9:0] A_SUSPEND_7     = 10'h35c;
  localparam logic [9:0] A_RESUME        = 10'h35d;
  localparam logic [9:0] A_IRQ_CLEAR     = 10'h35e;
  localparam logic [9:0] A_STATUS_LAST   = 10'h35f;

endpackage

`default_nettype wire

### src/coprocessor_host_register_file_core.sv
// ----------------------------------------------------------------------------
// Coprocessor host register file core
// Host byte window over DMA, program, cache, wait-state and flag registers,
// with vector bytes and general register bytes held in one byte RAM.
// ----------------------------------------------------------------------------
// The byte RAM is read when the input transfer completes, and the result is
// formed and the state written back during execution, so a new request
// is accepted only after the last has left execution. The vector bytes and
// the bytes of the sixteen general registers share an 80-entry byte RAM with
// a valid bit per entry, so no clearing pass follows reset. A finished
// result waits in an output register while the next request is accepted;
// that request then holds in execution until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module coprocessor_host_register_file_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire chrf_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output chrf_pkg::out_t     out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  chrf_pkg::in_t  item_r;
  chrf_pkg::out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [23:0] dma_src_r, dma_src_nxt;
  logic [15:0] dma_len_r, dma_len_nxt;
  logic [23:0] dma_tgt_r, dma_tgt_nxt;
  logic        preload_r, preload_nxt;
  logic [1:0]  lock_r, lock_nxt;
  logic [23:0] prog_ofs_r, prog_ofs_nxt;
  logic [14:0] page_r, page_nxt;
  logic [7:0]  pc_byte_r, pc_byte_nxt;
  logic [5:0]  wait_r, wait_nxt;
  logic [1:0]  misc_r, misc_nxt;
  logic        susp_r, susp_nxt;
  logic        halt_r, halt_nxt;
  logic        pend_r, pend_nxt;
  logic [chrf_pkg::MEM_DEPTH-1:0] mem_valid_r, mem_valid_nxt;

  logic                        in_xfer;
  logic                        exec_go;
  logic [chrf_pkg::MEM_AW-1:0] rd_idx;
  logic [chrf_pkg::MEM_AW-1:0] wr_idx;
  logic [7:0]                  mem_rdata;
  logic                        mem_we;
  logic                        item_vec;
  logic                        item_gpr;
  logic [7:0]                  mem_byte;
  logic [7:0]                  mdr_byte;
  logic [7:0]                  status_byte;

  function automatic logic is_vec(input logic [9:0] a);
    return a[9:5] == 5'b11011;
  endfunction

  function automatic logic is_gpr(input logic [9:0] a);
    return (a[9:7] == 3'b111) && (a[5:4] != 2'b11);
  endfunction

  function automatic logic [chrf_pkg::MEM_AW-1:0] mem_index(input logic [9:0] a);
    if (is_vec(a)) begin
      return {2'b00, a[4:0]};
    end
    return chrf_pkg::GPR_BASE + {1'b0, a[5:0]};
  endfunction

  // Remainder by three through base-four digit sums.
  function automatic logic [1:0] mod3(input logic [5:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]};
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign exec_go  = (state_r == S_EXEC) && !(out_valid_r && out_stall);
  assign rd_idx   = mem_index(in_data.addr);
  assign wr_idx   = mem_index(item_r.addr);
  assign item_vec = is_vec(item_r.addr);
  assign item_gpr = is_gpr(item_r.addr);
  assign mem_we   = exec_go && (item_r.req_type == chrf_pkg::REQ_WRITE) &&
                    (item_vec || (item_gpr && (halt_r || susp_r)));

  chrf_ram #(
    .WIDTH(8),
    .DEPTH(chrf_pkg::MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_idx),
    .wdata(item_r.wdata),
    .re   (in_xfer),
    .raddr(rd_idx),
    .rdata(mem_rdata)
  );

  assign mem_byte    = mem_valid_r[wr_idx] ? mem_rdata : 8'h00;
  assign status_byte = {item_r.core_bus_access, item_r.core_busy, 4'b0000, pend_r, susp_r};

  always_comb begin
    case (mod3(item_r.addr[5:0]))
      2'd0:    mdr_byte = item_r.core_mdr[7:0];
      2'd1:    mdr_byte = item_r.core_mdr[15:8];
      2'd2:    mdr_byte = item_r.core_mdr[23:16];
      default: mdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    dma_src_nxt   = dma_src_r;
    dma_len_nxt   = dma_len_r;
    dma_tgt_nxt   = dma_tgt_r;
    preload_nxt   = preload_r;
    lock_nxt      = lock_r;
    prog_ofs_nxt  = prog_ofs_r;
    page_nxt      = page_r;
    pc_byte_nxt   = pc_byte_r;
    wait_nxt      = wait_r;
    misc_nxt      = misc_r;
    susp_nxt      = susp_r;
    halt_nxt      = halt_r;
    pend_nxt      = pend_r;
    mem_valid_nxt = mem_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          out_nxt   = '0;
          if (mem_we) begin
            mem_valid_nxt[wr_idx] = 1'b1;
          end
          case (item_r.req_type)
            chrf_pkg::REQ_READ: begin
              unique case (item_r.addr)
                chrf_pkg::A_DMA_SRC0:      out_nxt.rdata = dma_src_r[7:0];
                chrf_pkg::A_DMA_SRC1:      out_nxt.rdata = dma_src_r[15:8];
                chrf_pkg::A_DMA_SRC2:      out_nxt.rdata = dma_src_r[23:16];
                chrf_pkg::A_DMA_LEN0:      out_nxt.rdata = dma_len_r[7:0];
                chrf_pkg::A_DMA_LEN1:      out_nxt.rdata = dma_len_r[15:8];
                chrf_pkg::A_DMA_TGT0:      out_nxt.rdata = dma_tgt_r[7:0];
                chrf_pkg::A_DMA_TGT1:      out_nxt.rdata = dma_tgt_r[15:8];
                chrf_pkg::A_DMA_TGT2:      out_nxt.rdata = dma_tgt_r[23:16];
                chrf_pkg::A_CACHE_PRELOAD: out_nxt.rdata = {7'b0, preload_r};
                chrf_pkg::A_PROG_OFS0:     out_nxt.rdata = prog_ofs_r[7:0];
                chrf_pkg::A_PROG_OFS1:     out_nxt.rdata = prog_ofs_r[15:8];
                chrf_pkg::A_PROG_OFS2:     out_nxt.rdata = prog_ofs_r[23:16];
                chrf_pkg::A_CACHE_LOCK:    out_nxt.rdata = {6'b0, lock_r};
                chrf_pkg::A_PAGE_LO:       out_nxt.rdata = page_r[7:0];
                chrf_pkg::A_PAGE_HI:       out_nxt.rdata = {1'b0, page_r[14:8]};
                chrf_pkg::A_PC_BYTE:       out_nxt.rdata = pc_byte_r;
                chrf_pkg::A_WAIT_STATES:
                  out_nxt.rdata = {1'b0, wait_r[5:3], 1'b0, wait_r[2:0]};
                chrf_pkg::A_IRQ_DISABLE:   out_nxt.rdata = {7'b0, misc_r[0]};
                chrf_pkg::A_SPARE_BIT:     out_nxt.rdata = {7'b0, misc_r[1]};
                chrf_pkg::A_HALT, chrf_pkg::A_STATUS_ALT, chrf_pkg::A_SUSPEND_0,
                chrf_pkg::A_SUSPEND_1, chrf_pkg::A_SUSPEND_2, chrf_pkg::A_SUSPEND_4,
                chrf_pkg::A_SUSPEND_6, chrf_pkg::A_SUSPEND_7, chrf_pkg::A_RESUME,
                chrf_pkg::A_IRQ_CLEAR, chrf_pkg::A_STATUS_LAST:
                  out_nxt.rdata = status_byte;
                default: begin
                  if (item_vec) begin
                    out_nxt.rdata = mem_byte;
                  end else if (item_gpr) begin
                    out_nxt.rdata = (!halt_r && !susp_r) ? mdr_byte : mem_byte;
                  end
                end
              endcase
            end
            chrf_pkg::REQ_HALT: begin
              halt_nxt = 1'b1;
            end
            chrf_pkg::REQ_IRQ: begin
              if (!misc_r[0]) begin
                pend_nxt = 1'b1;
              end
            end
            default: begin
              unique case (item_r.addr)
                chrf_pkg::A_DMA_SRC0: dma_src_nxt[7:0]   = item_r.wdata;
                chrf_pkg::A_DMA_SRC1: dma_src_nxt[15:8]  = item_r.wdata;
                chrf_pkg::A_DMA_SRC2: dma_src_nxt[23:16] = item_r.wdata;
                chrf_pkg::A_DMA_LEN0: dma_len_nxt[7:0]   = item_r.wdata;
                chrf_pkg::A_DMA_LEN1: dma_len_nxt[15:8]  = item_r.wdata;
                chrf_pkg::A_DMA_TGT0: dma_tgt_nxt[7:0]   = item_r.wdata;
                chrf_pkg::A_DMA_TGT1: dma_tgt_nxt[15:8]  = item_r.wdata;
                chrf_pkg::A_DMA_TGT2: begin
                  dma_tgt_nxt[23:16] = item_r.wdata;
                  out_nxt.dma_start  = halt_r;
                end
                chrf_pkg::A_CACHE_PRELOAD: begin
                  if (halt_r) begin
                    preload_nxt              = item_r.wdata[0];
                    out_nxt.cache_load_start = 1'b1;
                  end
                end
                chrf_pkg::A_PROG_OFS0: prog_ofs_nxt[7:0]   = item_r.wdata;
                chrf_pkg::A_PROG_OFS1: prog_ofs_nxt[15:8]  = item_r.wdata;
                chrf_pkg::A_PROG_OFS2: prog_ofs_nxt[23:16] = item_r.wdata;
                chrf_pkg::A_CACHE_LOCK: begin
                  if (halt_r) begin
                    lock_nxt = item_r.wdata[1:0];
                  end
                end
                chrf_pkg::A_PAGE_LO: page_nxt[7:0]  = item_r.wdata;
                chrf_pkg::A_PAGE_HI: page_nxt[14:8] = item_r.wdata[6:0];
                chrf_pkg::A_PC_BYTE: begin
                  pc_byte_nxt = item_r.wdata;
                  if (halt_r) begin
                    out_nxt.start_pulse = 1'b1;
                    out_nxt.start_pc    = {page_r, item_r.wdata};
                    halt_nxt            = 1'b0;
                  end
                end
                chrf_pkg::A_WAIT_STATES: wait_nxt = {item_r.wdata[6:4], item_r.wdata[2:0]};
                chrf_pkg::A_IRQ_DISABLE: begin
                  misc_nxt[0] = item_r.wdata[0];
                  if (item_r.wdata[0]) begin
                    pend_nxt = 1'b0;
                  end
                end
                chrf_pkg::A_SPARE_BIT: misc_nxt[1] = item_r.wdata[0];
                chrf_pkg::A_HALT:      halt_nxt = 1'b1;
                chrf_pkg::A_SUSPEND_0, chrf_pkg::A_SUSPEND_1, chrf_pkg::A_SUSPEND_2,
                chrf_pkg::A_SUSPEND_3, chrf_pkg::A_SUSPEND_4, chrf_pkg::A_SUSPEND_5,
                chrf_pkg::A_SUSPEND_6, chrf_pkg::A_SUSPEND_7: begin
                  susp_nxt               = 1'b1;
                  out_nxt.suspend_cycles = {3'(item_r.addr[3:0] - 4'h5), 5'b00000};
                end
                chrf_pkg::A_RESUME:    susp_nxt = 1'b0;
                chrf_pkg::A_IRQ_CLEAR: pend_nxt = 1'b0;
                default: begin
                end
              endcase
            end
          endcase
          out_nxt.irq_line       = pend_nxt && !misc_nxt[0];
          out_nxt.suspend_active = susp_nxt;
          out_nxt.halted         = halt_nxt;
          out_valid_nxt          = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dma_src_r   <= '0;
      dma_len_r   <= '0;
      dma_tgt_r   <= '0;
      preload_r   <= 1'b0;
      lock_r      <= '0;
      prog_ofs_r  <= '0;
      page_r      <= '0;
      pc_byte_r   <= '0;
      wait_r      <= '0;
      misc_r      <= '0;
      susp_r      <= 1'b0;
      halt_r      <= 1'b1;
      pend_r      <= 1'b0;
      mem_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dma_src_r   <= dma_src_nxt;
      dma_len_r   <= dma_len_nxt;
      dma_tgt_r   <= dma_tgt_nxt;
      preload_r   <= preload_nxt;
      lock_r      <= lock_nxt;
      prog_ofs_r  <= prog_ofs_nxt;
      page_r      <= page_nxt;
      pc_byte_r   <= pc_byte_nxt;
      wait_r      <= wait_nxt;
      misc_r      <= misc_nxt;
      susp_r      <= susp_nxt;
      halt_r      <= halt_nxt;
      pend_r      <= pend_nxt;
      mem_valid_r <= mem_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_xfer) begin
      item_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EXEC)
    else $error("accepted request did not enter execution");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> out_valid_r)
    else $error("execution produced no result");

  a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.irq_line == (pend_r && !misc_r[0])) && (out_r.halted == halt_r))
    else $error("result flags disagree with register state");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.start_pulse |-> !out_r.halted)
    else $error("program start left the core halted");

  a_dma_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.dma_start |-> out_r.halted)
    else $error("DMA start while running");

endmodule

`default_nettype wire

### src/chrf_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### dv/coprocessor_host_register_file_core_tb.sv
// ----------------------------------------------------------------------------
// Coprocessor host register file core testbench
// Sends host reads, host writes and core events into the register window and
// checks each result against a behavioral model of the window kept in the
// bench or a fixed directed reply. Requests idle in random bursts and once for
// a full drain; results stall on their own pattern with one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coprocessor_host_register_file_core_tb;
  import chrf_pkg::*;

  localparam int RANDOM_REQUESTS = 1150;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_POINT      = 400;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_POINT     = 700;
  localparam int TAIL_CYCLES     = 10;
  localparam int MAX_PRINTED     = 40;

  localparam logic [9:0] VEC_FIRST        = 10'h360;
  localparam logic [9:0] VEC_LAST         = 10'h37f;
  localparam logic [9:0] GPR_FIRST        = 10'h380;
  localparam logic [9:0] GPR_LAST         = 10'h3af;
  localparam logic [9:0] GPR_MIRROR_FIRST = 10'h3c0;
  localparam logic [9:0] GPR_MIRROR_LAST  = 10'h3ef;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } step_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  coprocessor_host_register_file_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Model of the register window.
  logic [23:0] dma_src;
  logic [15:0] dma_len;
  logic [23:0] dma_tgt;
  logic        preload;
  logic [1:0]  lock_bits;
  logic [23:0] prog_ofs;
  logic [14:0] page;
  logic [7:0]  pc_byte;
  logic [5:0]  wait_st;
  logic        irq_dis;
  logic        spare;
  logic        suspended;
  logic        halt_f;
  logic        irq_pend;
  logic [7:0]  vec [32];
  logic [23:0] gpr [16];

  out_t   want_q [$];
  step_t  directed_rows [$];
  int     n_sent;
  int     n_checked;
  int     n_errors;
  int     burst_left;
  int     n_reads;
  int     n_writes;
  int     n_events;
  int     n_starts;
  int     n_dma;
  int     n_suspends;
  int     n_live_reads;

  function automatic out_t window_access(input in_t rq);
    logic [9:0]  a;
    logic [7:0]  d;
    logic [5:0]  off;
    logic [9:0]  sdelta;
    int          idx;
    int          sh;
    bit          vec_hit;
    bit          gpr_hit;
    out_t        r;
    a = rq.addr;
    d = rq.wdata;
    r = '0;
    off = a[5:0];
    idx = int'(off) / 3;
    sh = int'(off) % 3;
    vec_hit = (a >= VEC_FIRST) && (a <= VEC_LAST);
    gpr_hit = ((a >= GPR_FIRST) && (a <= GPR_LAST)) ||
              ((a >= GPR_MIRROR_FIRST) && (a <= GPR_MIRROR_LAST));
    case (rq.req_type)
      REQ_READ: begin
        n_reads++;
        case (a)
          A_DMA_SRC0:      r.rdata = dma_src[7:0];
          A_DMA_SRC1:      r.rdata = dma_src[15:8];
          A_DMA_SRC2:      r.rdata = dma_src[23:16];
          A_DMA_LEN0:      r.rdata = dma_len[7:0];
          A_DMA_LEN1:      r.rdata = dma_len[15:8];
          A_DMA_TGT0:      r.rdata = dma_tgt[7:0];
          A_DMA_TGT1:      r.rdata = dma_tgt[15:8];
          A_DMA_TGT2:      r.rdata = dma_tgt[23:16];
          A_CACHE_PRELOAD: r.rdata = {7'b0, preload};
          A_PROG_OFS0:     r.rdata = prog_ofs[7:0];
          A_PROG_OFS1:     r.rdata = prog_ofs[15:8];
          A_PROG_OFS2:     r.rdata = prog_ofs[23:16];
          A_CACHE_LOCK:    r.rdata = {6'b0, lock_bits};
          A_PAGE_LO:       r.rdata = page[7:0];
          A_PAGE_HI:       r.rdata = {1'b0, page[14:8]};
          A_PC_BYTE:       r.rdata = pc_byte;
          A_WAIT_STATES:   r.rdata = {1'b0, wait_st[5:3], 1'b0, wait_st[2:0]};
          A_IRQ_DISABLE:   r.rdata = {7'b0, irq_dis};
          A_SPARE_BIT:     r.rdata = {7'b0, spare};
          A_HALT, A_STATUS_ALT, A_SUSPEND_0, A_SUSPEND_1, A_SUSPEND_2, A_SUSPEND_4,
          A_SUSPEND_6, A_SUSPEND_7, A_RESUME, A_IRQ_CLEAR, A_STATUS_LAST:
            r.rdata = {rq.core_bus_access, rq.core_busy, 4'b0, irq_pend, suspended};
          default: begin
            if (vec_hit) begin
              r.rdata = vec[a[4:0]];
            end else if (gpr_hit) begin
              if (!halt_f && !suspended) begin
                r.rdata = rq.core_mdr[8*sh +: 8];
                n_live_reads++;
              end else begin
                r.rdata = gpr[idx][8*sh +: 8];
              end
            end
          end
        endcase
      end
      REQ_HALT: begin
        n_events++;
        halt_f = 1'b1;
      end
      REQ_IRQ: begin
        n_events++;
        if (!irq_dis) irq_pend = 1'b1;
      end
      REQ_WRITE: begin
        n_writes++;
        case (a)
          A_DMA_SRC0: dma_src[7:0] = d;
          A_DMA_SRC1: dma_src[15:8] = d;
          A_DMA_SRC2: dma_src[23:16] = d;
          A_DMA_LEN0: dma_len[7:0] = d;
          A_DMA_LEN1: dma_len[15:8] = d;
          A_DMA_TGT0: dma_tgt[7:0] = d;
          A_DMA_TGT1: dma_tgt[15:8] = d;
          A_DMA_TGT2: begin
            dma_tgt[23:16] = d;
            if (halt_f) begin
              r.dma_start = 1'b1;
              n_dma++;
            end
          end
          A_CACHE_PRELOAD: begin
            if (halt_f) begin
              preload = d[0];
              r.cache_load_start = 1'b1;
            end
          end
          A_PROG_OFS0: prog_ofs[7:0] = d;
          A_PROG_OFS1: prog_ofs[15:8] = d;
          A_PROG_OFS2: prog_ofs[23:16] = d;
          A_CACHE_LOCK: begin
            if (halt_f) lock_bits = d[1:0];
          end
          A_PAGE_LO: page[7:0] = d;
          A_PAGE_HI: page[14:8] = d[6:0];
          A_PC_BYTE: begin
            pc_byte = d;
            if (halt_f) begin
              r.start_pulse = 1'b1;
              r.start_pc = {page, pc_byte};
              halt_f = 1'b0;
              n_starts++;
            end
          end
          A_WAIT_STATES: wait_st = {d[6:4], d[2:0]};
          A_IRQ_DISABLE: begin
            irq_dis = d[0];
            if (d[0]) irq_pend = 1'b0;
          end
          A_SPARE_BIT: spare = d[0];
          A_HALT: halt_f = 1'b1;
          A_SUSPEND_0, A_SUSPEND_1, A_SUSPEND_2, A_SUSPEND_3,
          A_SUSPEND_4, A_SUSPEND_5, A_SUSPEND_6, A_SUSPEND_7: begin
            suspended = 1'b1;
            sdelta = a - A_SUSPEND_0;
            r.suspend_cycles = {sdelta[2:0], 5'b0};
            n_suspends++;
          end
          A_RESUME: suspended = 1'b0;
          A_IRQ_CLEAR: irq_pend = 1'b0;
          default: begin
            if (vec_hit) begin
              vec[a[4:0]] = d;
            end else if (gpr_hit && (halt_f || suspended)) begin
              gpr[idx][8*sh +: 8] = d;
            end
          end
        endcase
      end
    endcase
    r.irq_line = irq_pend && !irq_dis;
    r.suspend_active = suspended;
    r.halted = halt_f;
    return r;
  endfunction

  function automatic in_t request(input logic [1:0] kind, input logic [9:0] addr,
                                  input logic [7:0] wdata);
    in_t r;
    r.req_type = kind;
    r.addr = addr;
    r.wdata = wdata;
    r.core_mdr = 24'($urandom());
    r.core_bus_access = 1'($urandom_range(0, 1));
    r.core_busy = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic in_t with_core(input in_t item, input logic [23:0] mdr,
                                    input logic bus, input logic busy);
    in_t r;
    r = item;
    r.core_mdr = mdr;
    r.core_bus_access = bus;
    r.core_busy = busy;
    return r;
  endfunction

  function automatic out_t reply(input logic [7:0] rdata, input logic irq,
                                 input logic start, input logic [22:0] pc,
                                 input logic dma, input logic cload, input logic susp,
                                 input logic [7:0] scyc, input logic halted);
    out_t r;
    r.rdata = rdata;
    r.irq_line = irq;
    r.start_pulse = start;
    r.start_pc = pc;
    r.dma_start = dma;
    r.cache_load_start = cload;
    r.suspend_active = susp;
    r.suspend_cycles = scyc;
    r.halted = halted;
    return r;
  endfunction

  function automatic logic [9:0] any_gpr_addr();
    logic [9:0] base;
    base = $urandom_range(0, 1) ? GPR_MIRROR_FIRST : GPR_FIRST;
    return base + 10'($urandom_range(0, 47));
  endfunction

  task automatic add_row(input in_t item, input bit typed, input out_t want);
    step_t s;
    s.item = item;
    s.typed = typed;
    s.want = want;
    directed_rows.push_back(s);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("mismatch in %s, result %0d at %0t: got 0x%0h, expected 0x%0h",
               what, n_checked, $time, got, want);
  endtask

  task automatic compare_result(input out_t got, input out_t want);
    if (got.rdata !== want.rdata)
      report_mismatch("rdata", 32'(got.rdata), 32'(want.rdata));
    if (got.irq_line !== want.irq_line)
      report_mismatch("irq_line", 32'(got.irq_line), 32'(want.irq_line));
    if (got.start_pulse !== want.start_pulse)
      report_mismatch("start_pulse", 32'(got.start_pulse), 32'(want.start_pulse));
    if (got.start_pc !== want.start_pc)
      report_mismatch("start_pc", 32'(got.start_pc), 32'(want.start_pc));
    if (got.dma_start !== want.dma_start)
      report_mismatch("dma_start", 32'(got.dma_start), 32'(want.dma_start));
    if (got.cache_load_start !== want.cache_load_start)
      report_mismatch("cache_load_start", 32'(got.cache_load_start),
                      32'(want.cache_load_start));
    if (got.suspend_active !== want.suspend_active)
      report_mismatch("suspend_active", 32'(got.suspend_active),
                      32'(want.suspend_active));
    if (got.suspend_cycles !== want.suspend_cycles)
      report_mismatch("suspend_cycles", 32'(got.suspend_cycles),
                      32'(want.suspend_cycles));
    if (got.halted !== want.halted)
      report_mismatch("halted", 32'(got.halted), 32'(want.halted));
  endtask

  task automatic issue(input in_t item, input bit typed, input out_t typed_want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = window_access(item);
    want_q.push_back(typed ? typed_want : predicted);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (want_q.size() == 0)
        report_mismatch("result with nothing expected", {24'b0, out_data.rdata}, 32'h0);
      else
        compare_result(out_data, want_q.pop_front());
      n_checked++;
    end
  end

  initial begin : receiver
    int   cyc;
    int   hold_left;
    bit   hold_done;
    logic stall;
    out_stall <= 1'b0;
    cyc = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_done && n_sent >= HOLD_POINT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stall = 1'b1;
      end else begin
        case ((cyc / 97) % 4)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 3) == 0);
          2: stall = ($urandom_range(0, 3) != 0);
          default: stall = ((cyc % 7) < 3);
        endcase
      end
      out_stall <= stall;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        idle = 0;
      else
        idle++;
    end
    $display("no transfer for %0d cycles, %0d results still expected",
             IDLE_LIMIT, want_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_t item;
    int  pick;
    int  total;
    bit  drained;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    dma_src = '0;
    dma_len = '0;
    dma_tgt = '0;
    preload = 1'b0;
    lock_bits = '0;
    prog_ofs = '0;
    page = '0;
    pc_byte = '0;
    wait_st = '0;
    irq_dis = 1'b0;
    spare = 1'b0;
    suspended = 1'b0;
    halt_f = 1'b1;
    irq_pend = 1'b0;
    foreach (vec[i]) vec[i] = '0;
    foreach (gpr[i]) gpr[i] = '0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    n_reads = 0;
    n_writes = 0;
    n_events = 0;
    n_starts = 0;
    n_dma = 0;
    n_suspends = 0;
    n_live_reads = 0;
    burst_left = 20;
    drained = 1'b0;

    add_row(with_core(request(REQ_READ, A_DMA_SRC0, 8'h00), 24'h000000, 1'b0, 1'b0),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
    add_row(with_core(request(REQ_READ, 10'h000, 8'hff), 24'hffffff, 1'b1, 1'b1),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
    add_row(with_core(request(REQ_READ, A_STATUS_ALT, 8'h00), 24'h000000, 1'b1, 1'b1),
            1'b1, reply(8'hc0, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
    add_row(request(REQ_WRITE, A_DMA_SRC0, 8'hff), 1'b0, '0);
    add_row(request(REQ_WRITE, A_DMA_TGT2, 8'hff),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1));
    add_row(request(REQ_WRITE, A_CACHE_PRELOAD, 8'hff),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
    add_row(request(REQ_WRITE, A_CACHE_LOCK, 8'hff), 1'b0, '0);
    add_row(request(REQ_WRITE, A_PAGE_LO, 8'hff), 1'b0, '0);
    add_row(request(REQ_WRITE, A_PAGE_HI, 8'hff), 1'b0, '0);
    add_row(request(REQ_WRITE, A_WAIT_STATES, 8'hff), 1'b0, '0);
    add_row(request(REQ_READ, A_WAIT_STATES, 8'h00),
            1'b1, reply(8'h77, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
    add_row(request(REQ_WRITE, GPR_MIRROR_LAST, 8'hcd), 1'b0, '0);
    add_row(request(REQ_READ, GPR_LAST, 8'h00), 1'b0, '0);
    add_row(request(REQ_WRITE, VEC_LAST, 8'h5a), 1'b0, '0);
    add_row(request(REQ_READ, VEC_LAST, 8'h00), 1'b0, '0);
    add_row(request(REQ_WRITE, A_PC_BYTE, 8'hff),
            1'b1, reply(8'h00, 1'b0, 1'b1, 23'h7fffff, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    add_row(with_core(request(REQ_READ, GPR_FIRST, 8'h00), 24'ha5c33c, 1'b0, 1'b0),
            1'b1, reply(8'h3c, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    add_row(request(REQ_WRITE, GPR_FIRST, 8'h12), 1'b0, '0);
    add_row(request(REQ_WRITE, A_CACHE_PRELOAD, 8'h00),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    add_row(request(REQ_IRQ, 10'h3ff, 8'h00),
            1'b1, reply(8'h00, 1'b1, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    add_row(request(REQ_WRITE, A_IRQ_DISABLE, 8'h01), 1'b0, '0);
    add_row(request(REQ_IRQ, 10'h000, 8'hff), 1'b0, '0);
    add_row(request(REQ_WRITE, A_SUSPEND_7, 8'h00),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b1, 8'he0, 1'b0));
    add_row(request(REQ_READ, A_SUSPEND_3, 8'h00), 1'b0, '0);
    add_row(with_core(request(REQ_READ, A_SUSPEND_4, 8'h00), 24'h000000, 1'b1, 1'b0),
            1'b0, '0);
    add_row(request(REQ_WRITE, A_RESUME, 8'h00), 1'b0, '0);
    add_row(request(REQ_HALT, 10'h155, 8'haa),
            1'b1, reply(8'h00, 1'b0, 1'b0, 23'h0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    total = directed_rows.size() + RANDOM_REQUESTS;
    while (n_sent < total) begin
      if (!drained && n_sent >= DRAIN_POINT) begin
        drained = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        if ($urandom_range(0, 1) != 0)
          issue(request(REQ_HALT, 10'($urandom()), 8'($urandom())), 1'b0, '0);
        else
          issue(request(REQ_WRITE, A_HALT, 8'($urandom())), 1'b0, '0);
        issue(request(REQ_WRITE, A_PAGE_LO, 8'($urandom())), 1'b0, '0);
        issue(request(REQ_WRITE, A_PAGE_HI, 8'($urandom())), 1'b0, '0);
        issue(request(REQ_WRITE, any_gpr_addr(), 8'($urandom())), 1'b0, '0);
        issue(request(REQ_WRITE, A_PC_BYTE, 8'($urandom())), 1'b0, '0);
        repeat ($urandom_range(1, 4))
          issue(request(REQ_READ, any_gpr_addr(), 8'($urandom())), 1'b0, '0);
      end else if (pick < 12) begin
        issue(request(REQ_WRITE, A_SUSPEND_0 + 10'($urandom_range(0, 7)), 8'($urandom())),
              1'b0, '0);
        repeat ($urandom_range(1, 3))
          issue(request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, any_gpr_addr(),
                        8'($urandom())), 1'b0, '0);
        issue(request(REQ_WRITE, A_RESUME, 8'($urandom())), 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)
          item = request(REQ_WRITE, A_DMA_SRC0 + 10'($urandom_range(0, 31)),
                         8'($urandom()));
        else if (pick < 55)
          item = request(REQ_READ, A_DMA_SRC0 + 10'($urandom_range(0, 31)),
                         8'($urandom()));
        else if (pick < 75)
          item = request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                         VEC_FIRST + 10'($urandom_range(0, 159)), 8'($urandom()));
        else if (pick < 81)
          item = request(REQ_HALT, 10'($urandom()), 8'($urandom()));
        else if (pick < 87)
          item = request(REQ_IRQ, 10'($urandom()), 8'($urandom()));
        else
          item = request(2'($urandom()), 10'($urandom()), 8'($urandom()));
        issue(item, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (want_q.size() != 0)
      report_mismatch("results never delivered", want_q.size(), 32'h0);

    $display("covered %0d requests: %0d reads, %0d writes, %0d core events",
             n_sent, n_reads, n_writes, n_events);
    $display("%0d starts, %0d DMA, %0d suspends, %0d live GPR reads, %0d checked, %0d errors",
             n_starts, n_dma, n_suspends, n_live_reads, n_checked, n_errors);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
src/chrf_pkg.sv
src/chrf_ram.sv
src/coprocessor_host_register_file_core.sv
dv/coprocessor_host_register_file_core_tb.sv
